>>> src/bchd_pkg.sv
// ----------------------------------------------------------------------------
// bchd_pkg
// Shared types and constants for the button click and hold detector: the
// per-button mode and event codes, the register indexes, the sample and
// result words, and the layout of one entry of the per-button state memory.
// ----------------------------------------------------------------------------
package bchd_pkg;

	localparam int ButtonCount = 2;
	localparam int ButtonIdxW  = 1;
	localparam int TimeW       = 32;
	localparam int CfgIdxW     = 3;
	localparam int CfgDataW    = 16;

	localparam logic [15:0] DebounceTimeReset = 16'd20;
	localparam logic [15:0] ClickTimeoutReset = 16'd280;
	localparam logic [15:0] HoldTimeReset     = 16'd2500;
	localparam logic        AutoOffReset      = 1'b1;
	localparam logic        PowerButtonReset  = 1'b1;

	typedef enum logic [2:0] {
		MODE_WAIT_RELEASE = 3'd0,
		MODE_IDLE         = 3'd1,
		MODE_DEB_PRESS    = 3'd2,
		MODE_PRESSED      = 3'd3,
		MODE_DEB_RELEASE  = 3'd4,
		MODE_WAIT_SECOND  = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_DOWN   = 3'd1,
		EV_LONG   = 3'd2,
		EV_UP     = 3'd3,
		EV_SINGLE = 3'd4,
		EV_DOUBLE = 3'd5
	} event_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_DEBOUNCE_TIME = 3'd0,
		REG_CLICK_TIMEOUT = 3'd1,
		REG_HOLD_TIME     = 3'd2,
		REG_AUTO_OFF      = 3'd3,
		REG_POWER_BUTTON  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [ButtonIdxW-1:0] button;
		logic                  pressed;
		logic [TimeW-1:0]      now_ms;
	} sample_t;

	typedef struct packed {
		logic [ButtonIdxW-1:0] button_out;
		event_t                event_res;
		logic                  power_off_request;
	} result_t;

	typedef struct packed {
		mode_t            mode;
		logic [TimeW-1:0] debounce_start;
		logic [TimeW-1:0] press_start;
		logic [TimeW-1:0] release_time;
		logic             long_reported;
	} entry_t;

	localparam entry_t EntryReset = '{
		mode:           MODE_WAIT_RELEASE,
		debounce_start: '0,
		press_start:    '0,
		release_time:   '0,
		long_reported:  1'b0
	};

endpackage

>>> src/button_click_hold_detector_top.sv
// ----------------------------------------------------------------------------
// button_click_hold_detector_top
// Debounces periodic button samples and reports press-down, long press,
// press-up, single click and double click per button, with a one-time
// power-off request on a long press of the power button.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                       Word
//   sample    in         sample_valid / sample_stall     bchd_pkg::sample_t
//   result    out        result_valid / result_stall     bchd_pkg::result_t
//   config    in         cfg_we (no handshake back)      cfg_idx, cfg_wdata
//
// A sample word is taken every cycle while the result side keeps up. The state
// memory is read at the edge that takes the word, the update stage works on it,
// and its result word goes into the output register when the stage advances.
// The per-button state memory has one write and one read port; when a word
// reads the entry that the word ahead of it is writing in the same cycle, the
// new entry is bypassed into the read register. Reset clears the valid flags,
// the halt flag and the entry valid bits and loads the register reset values
// at once, so the block is ready in the first cycle after reset. When the
// result register is full and stalled, the update stage holds its word and
// the sample side is stalled in turn.
//
module button_click_hold_detector_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             sample_valid,
	output logic                             sample_stall,
	input  bchd_pkg::sample_t                sample,
	output logic                             result_valid,
	input  logic                             result_stall,
	output bchd_pkg::result_t                result,
	input  logic                             cfg_we,
	input  logic [bchd_pkg::CfgIdxW-1:0]     cfg_idx,
	input  logic [bchd_pkg::CfgDataW-1:0]    cfg_wdata
);

	// Configuration registers.
	logic [15:0] debounce_time_q;
	logic [15:0] click_timeout_q;
	logic [15:0] hold_time_q;
	logic        auto_off_q;
	logic        power_button_q;

	// Per-button state memory with one valid bit per entry; an entry that has
	// never been written reads as the reset entry.
	bchd_pkg::entry_t                   mem_q [bchd_pkg::ButtonCount];
	logic [bchd_pkg::ButtonCount-1:0]   entry_vld_q;

	// Update stage: the accepted word and the entry read for it.
	logic               vld_s1;
	bchd_pkg::sample_t  sample_s1;
	bchd_pkg::entry_t   entry_s1;

	// Output register and the global halt flag.
	logic               result_valid_q;
	bchd_pkg::result_t  result_q;
	logic               halted_q;

	logic               advance;
	logic               accept;
	logic               active;
	logic               wr_en;
	logic               bypass;
	bchd_pkg::entry_t   entry_new;
	bchd_pkg::event_t   ev;
	logic               poff;

	// The word held in the update stage leaves when the output register is
	// empty or is being emptied in this cycle.
	assign advance      = vld_s1 && (!result_valid_q || !result_stall);
	assign sample_stall = vld_s1 && !advance;
	assign accept       = sample_valid && !sample_stall;

	// Halted, or an index that no button has: the word passes with no event.
	assign active = !halted_q && (32'(sample_s1.button) < bchd_pkg::ButtonCount);
	assign wr_en  = advance && active;
	assign bypass = wr_en && (sample_s1.button == sample.button);

	function automatic logic elapsed(input logic [bchd_pkg::TimeW-1:0] now,
			input logic [bchd_pkg::TimeW-1:0] since, input logic [15:0] limit);
		logic [bchd_pkg::TimeW-1:0] diff;
		diff = now - since;
		return diff >= {16'b0, limit};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_time_q <= bchd_pkg::DebounceTimeReset;
			click_timeout_q <= bchd_pkg::ClickTimeoutReset;
			hold_time_q     <= bchd_pkg::HoldTimeReset;
			auto_off_q      <= bchd_pkg::AutoOffReset;
			power_button_q  <= bchd_pkg::PowerButtonReset;
		end else if (cfg_we) begin
			unique case (bchd_pkg::cfg_reg_t'(cfg_idx))
				bchd_pkg::REG_DEBOUNCE_TIME: debounce_time_q <= cfg_wdata;
				bchd_pkg::REG_CLICK_TIMEOUT: click_timeout_q <= cfg_wdata;
				bchd_pkg::REG_HOLD_TIME:     hold_time_q     <= cfg_wdata;
				bchd_pkg::REG_AUTO_OFF:      auto_off_q      <= cfg_wdata[0];
				bchd_pkg::REG_POWER_BUTTON:  power_button_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Read side of the memory, with the bypass from the write port.
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			if (bypass) begin
				entry_s1 <= entry_new;
			end else if (entry_vld_q[sample.button]) begin
				entry_s1 <= mem_q[sample.button];
			end else begin
				entry_s1 <= bchd_pkg::EntryReset;
			end
		end
	end

	// Write side of the memory.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[sample_s1.button] <= entry_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q    <= '0;
			vld_s1         <= 1'b0;
			result_valid_q <= 1'b0;
			halted_q       <= 1'b0;
		end else begin
			if (wr_en) begin
				entry_vld_q[sample_s1.button] <= 1'b1;
			end
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (advance) begin
				vld_s1 <= 1'b0;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (advance && poff) begin
				halted_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.button_out        <= sample_s1.button;
			result_q.event_res         <= active ? ev : bchd_pkg::EV_NONE;
			result_q.power_off_request <= active && poff;
		end
	end

	// Per-button mode machine: next entry and event for the word in stage 1.
	always_comb begin
		entry_new = entry_s1;
		ev        = bchd_pkg::EV_NONE;
		unique case (entry_s1.mode)
			bchd_pkg::MODE_WAIT_RELEASE: begin
				if (!sample_s1.pressed) begin
					entry_new.mode = bchd_pkg::MODE_IDLE;
				end
			end
			bchd_pkg::MODE_DEB_PRESS: begin
				if (sample_s1.pressed) begin
					if (elapsed(sample_s1.now_ms, entry_s1.debounce_start,
							debounce_time_q)) begin
						entry_new.mode          = bchd_pkg::MODE_PRESSED;
						entry_new.press_start   = sample_s1.now_ms;
						entry_new.long_reported = 1'b0;
						ev                      = bchd_pkg::EV_DOWN;
					end
				end else begin
					entry_new.mode = bchd_pkg::MODE_IDLE;
				end
			end
			bchd_pkg::MODE_PRESSED: begin
				if (sample_s1.pressed) begin
					if (!entry_s1.long_reported && elapsed(sample_s1.now_ms,
							entry_s1.press_start, hold_time_q)) begin
						entry_new.long_reported = 1'b1;
						ev                      = bchd_pkg::EV_LONG;
					end
				end else begin
					entry_new.mode           = bchd_pkg::MODE_DEB_RELEASE;
					entry_new.debounce_start = sample_s1.now_ms;
				end
			end
			bchd_pkg::MODE_DEB_RELEASE: begin
				if (!sample_s1.pressed) begin
					if (elapsed(sample_s1.now_ms, entry_s1.debounce_start,
							debounce_time_q)) begin
						ev = bchd_pkg::EV_UP;
						if (entry_s1.long_reported) begin
							entry_new.mode = bchd_pkg::MODE_IDLE;
						end else begin
							entry_new.mode         = bchd_pkg::MODE_WAIT_SECOND;
							entry_new.release_time = sample_s1.now_ms;
						end
					end
				end else begin
					entry_new.mode = bchd_pkg::MODE_PRESSED;
				end
			end
			bchd_pkg::MODE_WAIT_SECOND: begin
				if (sample_s1.pressed) begin
					entry_new.mode           = bchd_pkg::MODE_DEB_PRESS;
					entry_new.debounce_start = sample_s1.now_ms;
					ev                       = bchd_pkg::EV_DOUBLE;
				end else if (elapsed(sample_s1.now_ms, entry_s1.release_time,
						click_timeout_q)) begin
					entry_new.mode = bchd_pkg::MODE_IDLE;
					ev             = bchd_pkg::EV_SINGLE;
				end
			end
			default: begin
				// Idle, and any code that has no meaning, behave as idle.
				entry_new.mode = bchd_pkg::MODE_IDLE;
				if (sample_s1.pressed) begin
					entry_new.mode           = bchd_pkg::MODE_DEB_PRESS;
					entry_new.debounce_start = sample_s1.now_ms;
				end
			end
		endcase
		poff = (ev == bchd_pkg::EV_LONG) && (sample_s1.button == power_button_q)
			&& auto_off_q;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

>>> test/bchd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bchd_checker
// Watches the sample, result and register write ports of the button click
// and hold detector. It keeps its own copy of the per-button modes and time
// stamps and of the registers. It works out the event word for every
// accepted sample and compares each accepted result word with it.
// ----------------------------------------------------------------------------
module bchd_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	input  logic                          sample_stall,
	input  bchd_pkg::sample_t             sample,
	input  logic                          result_valid,
	input  logic                          result_stall,
	input  bchd_pkg::result_t             result,
	input  logic                          cfg_we,
	input  logic [bchd_pkg::CfgIdxW-1:0]  cfg_idx,
	input  logic [bchd_pkg::CfgDataW-1:0] cfg_wdata,
	output int unsigned                   errors,
	output int unsigned                   outstanding
);
	import bchd_pkg::*;

	logic [15:0]      settle_ms;
	logic [15:0]      click_window_ms;
	logic [15:0]      hold_ms;
	logic             auto_off_en;
	logic             power_btn;

	mode_t            btn_mode    [ButtonCount];
	logic [TimeW-1:0] settle_from [ButtonCount];
	logic [TimeW-1:0] held_from   [ButtonCount];
	logic [TimeW-1:0] let_go_at   [ButtonCount];
	logic             long_seen   [ButtonCount];
	logic             powered_down;

	result_t          pending_events[$];

	// Time differences wrap, so a stamp that runs backwards counts as long gone.
	function automatic logic reached(logic [TimeW-1:0] now, logic [TimeW-1:0] since,
			logic [15:0] span);
		logic [TimeW-1:0] diff;
		diff = now - since;
		return diff >= TimeW'(span);
	endfunction

	function automatic result_t button_event(sample_t s);
		result_t               r;
		event_t                ev;
		logic [ButtonIdxW-1:0] b;
		r = '{button_out: s.button, event_res: EV_NONE, power_off_request: 1'b0};
		ev = EV_NONE;
		b = s.button;
		if (powered_down || 32'(b) >= ButtonCount)
			return r;
		case (btn_mode[b])
		MODE_WAIT_RELEASE: begin
			if (!s.pressed)
				btn_mode[b] = MODE_IDLE;
		end
		MODE_DEB_PRESS: begin
			if (!s.pressed) begin
				btn_mode[b] = MODE_IDLE;
			end else if (reached(s.now_ms, settle_from[b], settle_ms)) begin
				btn_mode[b] = MODE_PRESSED;
				held_from[b] = s.now_ms;
				long_seen[b] = 1'b0;
				ev = EV_DOWN;
			end
		end
		MODE_PRESSED: begin
			if (!s.pressed) begin
				btn_mode[b] = MODE_DEB_RELEASE;
				settle_from[b] = s.now_ms;
			end else if (!long_seen[b] && reached(s.now_ms, held_from[b], hold_ms)) begin
				long_seen[b] = 1'b1;
				ev = EV_LONG;
			end
		end
		MODE_DEB_RELEASE: begin
			if (s.pressed) begin
				btn_mode[b] = MODE_PRESSED;
			end else if (reached(s.now_ms, settle_from[b], settle_ms)) begin
				ev = EV_UP;
				if (long_seen[b]) begin
					btn_mode[b] = MODE_IDLE;
				end else begin
					btn_mode[b] = MODE_WAIT_SECOND;
					let_go_at[b] = s.now_ms;
				end
			end
		end
		MODE_WAIT_SECOND: begin
			if (s.pressed) begin
				btn_mode[b] = MODE_DEB_PRESS;
				settle_from[b] = s.now_ms;
				ev = EV_DOUBLE;
			end else if (reached(s.now_ms, let_go_at[b], click_window_ms)) begin
				btn_mode[b] = MODE_IDLE;
				ev = EV_SINGLE;
			end
		end
		default: begin
			btn_mode[b] = MODE_IDLE;
			if (s.pressed) begin
				btn_mode[b] = MODE_DEB_PRESS;
				settle_from[b] = s.now_ms;
			end
		end
		endcase
		if (ev == EV_LONG && s.button == power_btn && auto_off_en) begin
			r.power_off_request = 1'b1;
			powered_down = 1'b1;
		end
		r.event_res = ev;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			settle_ms = DebounceTimeReset;
			click_window_ms = ClickTimeoutReset;
			hold_ms = HoldTimeReset;
			auto_off_en = AutoOffReset;
			power_btn = PowerButtonReset;
			for (int k = 0; k < ButtonCount; k++) begin
				btn_mode[k] = MODE_WAIT_RELEASE;
				settle_from[k] = '0;
				held_from[k] = '0;
				let_go_at[k] = '0;
				long_seen[k] = 1'b0;
			end
			powered_down = 1'b0;
			pending_events.delete();
			errors = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
				REG_DEBOUNCE_TIME: settle_ms = cfg_wdata;
				REG_CLICK_TIMEOUT: click_window_ms = cfg_wdata;
				REG_HOLD_TIME:     hold_ms = cfg_wdata;
				REG_AUTO_OFF:      auto_off_en = cfg_wdata[0];
				REG_POWER_BUTTON:  power_btn = cfg_wdata[0];
				default:           ;
				endcase
			end
			// Results are matched before this edge's sample is queued, so a
			// stray result word is never paired with a word just taken in.
			if (result_valid && !result_stall) begin
				if (pending_events.size() == 0) begin
					$error("result word with no sample outstanding: %p", result);
					errors++;
				end else begin
					want = pending_events.pop_front();
					if (result.button_out !== want.button_out) begin
						$error("button_out: expected %0d, got %0d",
							want.button_out, result.button_out);
						errors++;
					end
					if (result.event_res !== want.event_res) begin
						$error("event_res: expected %0d, got %0d",
							want.event_res, result.event_res);
						errors++;
					end
					if (result.power_off_request !== want.power_off_request) begin
						$error("power_off_request: expected %0d, got %0d",
							want.power_off_request, result.power_off_request);
						errors++;
					end
				end
			end
			if (sample_valid && !sample_stall)
				pending_events.push_back(button_event(sample));
			outstanding <= pending_events.size();
		end
	end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives button samples and register writes into the click and hold detector
// and leaves the prediction and comparison to bchd_checker. A directed set of
// samples walks every mode and event at the reset settings, then several
// register settings follow, each with random press and release sequences.
// ----------------------------------------------------------------------------
module tb;
	import bchd_pkg::*;

	// Written to check that an index past the register list changes nothing.
	localparam logic [CfgIdxW-1:0] RegBeyondList = 3'd7;
	localparam int                 SqueezeCycles = 48;
	localparam int                 CycleLimit    = 200000;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                sample_valid = 1'b0;
	logic                sample_stall;
	sample_t             sample       = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	result_t             result;
	logic                cfg_we       = 1'b0;
	logic [CfgIdxW-1:0]  cfg_idx      = REG_DEBOUNCE_TIME;
	logic [CfgDataW-1:0] cfg_wdata    = '0;

	int unsigned         errors;
	int unsigned         outstanding;
	int unsigned         cycle_count  = 0;

	// Stimulus-side knowledge: the current register values, so that time gaps
	// can be aimed at the thresholds, and each button's last level and stamp.
	logic [15:0]         deb_cfg      = DebounceTimeReset;
	logic [15:0]         click_cfg    = ClickTimeoutReset;
	logic [15:0]         hold_cfg     = HoldTimeReset;
	logic                level [ButtonCount];
	logic [TimeW-1:0]    stamp [ButtonCount];

	// In the last part of the run neither side idles.
	logic                calm         = 1'b0;
	logic                squeeze_req  = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	button_click_hold_detector_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata)
	);

	bchd_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.errors       (errors),
		.outstanding  (outstanding)
	);

	// Sends one sample word and returns at the edge where it was taken. The
	// valid stays high afterwards, so back-to-back words need no gap. Now and
	// then the word is held back for a short burst of idle cycles first.
	task automatic put(input logic b, input logic p, input logic [TimeW-1:0] t);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 6);
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample <= '{button: b, pressed: p, now_ms: t};
		sample_valid <= 1'b1;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		level[b] = p;
		stamp[b] = t;
	endtask

	// Picks the time step to the next sample of a button. Many steps land just
	// below, on or just above one of the thresholds, so that every comparison
	// is tried at its edge; a few are arbitrary and may run the clock backwards.
	function automatic logic [TimeW-1:0] near(logic [15:0] v);
		if (v == 0)
			return $urandom_range(0, 1);
		return TimeW'(v) - 1 + $urandom_range(0, 2);
	endfunction

	function automatic logic [TimeW-1:0] next_gap();
		case ($urandom_range(0, 19))
		0, 1, 2, 3: return $urandom_range(0, 3);
		4, 5, 6:    return near(deb_cfg);
		7, 8:       return near(click_cfg);
		9, 10, 11:  return TimeW'(hold_cfg / 4) + $urandom_range(0, 2);
		12, 13:     return near(hold_cfg);
		14, 15:     return $urandom_range(0, hold_cfg);
		16:         return $urandom;
		default:    return $urandom_range(0, 12);
		endcase
	endfunction

	// A quarter of the samples change the level; the rest keep it, so that
	// presses last long enough to be debounced and held.
	task automatic random_sample();
		logic b;
		logic p;
		b = ButtonIdxW'($urandom_range(0, ButtonCount - 1));
		p = level[b];
		if ($urandom_range(0, 3) == 0)
			p = ~p;
		put(b, p, stamp[b] + next_gap());
	endtask

	// Drops valid and waits until every result word has been checked.
	task automatic drain();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Writes every register in turn, plus one index past the list. The one-bit
	// registers get junk in the upper data bits, which must be ignored.
	task automatic program_regs(input logic [15:0] deb, input logic [15:0] click,
			input logic [15:0] hold, input logic aoff, input logic pbtn);
		cfg_we <= 1'b1;
		cfg_idx <= REG_DEBOUNCE_TIME;
		cfg_wdata <= deb;
		@(posedge clk);
		cfg_idx <= REG_CLICK_TIMEOUT;
		cfg_wdata <= click;
		@(posedge clk);
		cfg_idx <= REG_HOLD_TIME;
		cfg_wdata <= hold;
		@(posedge clk);
		cfg_idx <= REG_AUTO_OFF;
		cfg_wdata <= {15'($urandom), aoff};
		@(posedge clk);
		cfg_idx <= REG_POWER_BUTTON;
		cfg_wdata <= {15'($urandom), pbtn};
		@(posedge clk);
		cfg_idx <= RegBeyondList;
		cfg_wdata <= 16'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		deb_cfg = deb;
		click_cfg = click;
		hold_cfg = hold;
	endtask

	// Receiver: short random stall bursts, one long hold-off on request while
	// the sender keeps offering words, and no stalls at all once calm is set.
	initial begin : receiver
		int   gap;
		logic squeezed;
		squeezed = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (squeeze_req && !squeezed) begin
				squeezed = 1'b1;
				result_stall <= 1'b1;
				for (int n = 0; n < SqueezeCycles; n++)
					@(posedge clk);
				result_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				gap = $urandom_range(1, 6);
				result_stall <= 1'b1;
				repeat (gap) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("button_click_hold_detector_top verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		logic [TimeW-1:0] t;
		for (int k = 0; k < ButtonCount; k++) begin
			level[k] = 1'b0;
			stamp[k] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: debounce 20, click window 280, hold 2500, auto
		// power-off on button 1. Button 1 starts held, so it must first be
		// seen released before anything counts.
		put(1'b1, 1'b1, 32'd0);
		put(1'b1, 1'b0, 32'd5);
		put(1'b0, 1'b0, 32'd0);
		// A bounce that falls back before the debounce time has passed.
		put(1'b0, 1'b1, 32'd100);
		put(1'b0, 1'b0, 32'd110);
		// A clean press on button 0: one short of the debounce time, then on it.
		put(1'b0, 1'b1, 32'd200);
		put(1'b0, 1'b1, 32'd219);
		put(1'b0, 1'b1, 32'd220);
		// Long press one short and then exactly on the hold time; it is
		// reported once only, and button 0 is not the power button.
		put(1'b0, 1'b1, 32'd2719);
		put(1'b0, 1'b1, 32'd2720);
		put(1'b0, 1'b1, 32'd5000);
		// A bounce on release returns to pressed, then a clean release. After
		// a long press the release goes straight back to idle.
		put(1'b0, 1'b0, 32'd5001);
		put(1'b0, 1'b1, 32'd5005);
		put(1'b0, 1'b0, 32'd5010);
		put(1'b0, 1'b0, 32'd5030);
		// Short press, release, and the click window running out: single click.
		put(1'b0, 1'b1, 32'd6000);
		put(1'b0, 1'b1, 32'd6020);
		put(1'b0, 1'b0, 32'd6100);
		put(1'b0, 1'b0, 32'd6120);
		put(1'b0, 1'b0, 32'd6399);
		put(1'b0, 1'b0, 32'd6400);
		// Double click on button 1 with the time stamp wrapping through zero.
		put(1'b1, 1'b1, 32'hFFFF_FFF0);
		put(1'b1, 1'b1, 32'h0000_0004);
		put(1'b1, 1'b0, 32'h0000_0010);
		put(1'b1, 1'b0, 32'h0000_0024);
		put(1'b1, 1'b1, 32'h0000_0030);
		put(1'b1, 1'b1, 32'h0000_0044);
		put(1'b1, 1'b0, 32'h0000_0050);

		// Short thresholds; power-off disabled, so long presses on the power
		// button are reported without halting.
		drain();
		program_regs(16'd5, 16'd30, 16'd100, 1'b0, 1'b1);
		repeat (80) random_sample();

		// All thresholds at zero: every comparison passes at once.
		drain();
		program_regs(16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
		repeat (60) random_sample();

		// All thresholds at their maximum.
		drain();
		program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
		repeat (60) random_sample();

		// Random thresholds, with one long hold-off on the result side part
		// way through so that the pipeline fills and stalls its input.
		drain();
		program_regs(16'($urandom_range(0, 60)), 16'($urandom_range(0, 400)),
			16'($urandom_range(0, 1000)), 1'b0, 1'($urandom));
		for (int n = 0; n < 120; n++) begin
			if (n == 40)
				squeeze_req = 1'b1;
			random_sample();
		end

		// Last part: no idling, power-off armed on button 0. Long presses on
		// button 1 must not halt the block; one on button 0 does, and every
		// word after that is ignored.
		drain();
		calm = 1'b1;
		program_regs(16'd3, 16'd20, 16'd60, 1'b1, 1'b0);
		repeat (80) random_sample();
		// Make sure the power-off request is reached: release button 0 until
		// it is idle, then press and hold it for the full hold time.
		t = stamp[0];
		put(1'b0, 1'b0, t + 1000);
		put(1'b0, 1'b0, t + 2000);
		put(1'b0, 1'b0, t + 3000);
		put(1'b0, 1'b1, t + 4000);
		put(1'b0, 1'b1, t + 4003);
		put(1'b0, 1'b1, t + 4063);
		repeat (10) random_sample();

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("button_click_hold_detector_top verification clean");
		else
			$display("button_click_hold_detector_top verification failed");
		$finish;
	end

endmodule
